@@ src/bfha_pkg.sv @@
// Shared types, constants and helpers of the best-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package bfha_pkg;

    localparam int HEAP_BYTES = 65536;
    localparam int HDR_BYTES  = 12;
    localparam int HDR_WORDS  = HDR_BYTES / 4;
    localparam int IDX_W      = $clog2(HEAP_BYTES / 4);
    localparam int DEPTH      = HEAP_BYTES / 4;
    localparam int BYTE_W     = 17;
    localparam int LINK_W     = IDX_W + 1;
    localparam int SIZE_W     = BYTE_W + 1;
    localparam int LIMIT_MIN  = 64;
    localparam int GLOG_MIN   = 2;
    localparam int GLOG_MAX   = 10;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LINK_W-1:0] link_t;

    // Top bit marks the end of a list or the absence of a neighbor.
    localparam link_t LINK_NIL = {1'b1, {IDX_W{1'b0}}};

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;
    localparam logic [1:0] OP_RESIZE  = 2'd3;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NO_SPACE = 2'd1;
    localparam logic [1:0] STS_BAD_ADDR = 2'd2;
    localparam logic [1:0] STS_IS_FREE  = 2'd3;

    localparam logic [1:0] CFG_HEAP_LIMIT = 2'd0;
    localparam logic [1:0] CFG_GRANULE    = 2'd1;

    typedef struct packed {
        logic [1:0]  operation;
        byte_t       block_addr;
        byte_t       req_size;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        byte_t       result_addr;
        byte_t       granted_size;
        logic        copy_needed;
        byte_t       copy_bytes;
    } out_item_t;

    typedef enum logic [5:0] {
        ST_CLR, ST_INIT, ST_IDLE, ST_DISP, ST_CHK,
        ST_RZ0, ST_RZ1, ST_RZ2,
        ST_GR_CHK, ST_GR_CMP, ST_GR_CV, ST_GR_END, ST_GR_SZ, ST_GR_SZ2,
        ST_LG_RD, ST_LG_CMP, ST_LG_SZ, ST_LG_SZ2,
        ST_CV0, ST_CV1, ST_CV2, ST_CV3, ST_CV4, ST_CV5, ST_CV_INS, ST_CV_END,
        ST_RL0, ST_RL1, ST_RL2, ST_RL3, ST_RL4, ST_RL5, ST_RL6, ST_RL7,
        ST_RL8, ST_RL9, ST_RL10, ST_RL11, ST_RL_END,
        ST_RM_CHK, ST_RM_ADV, ST_RM_FIX, ST_RM_FIX2,
        ST_IN_RD, ST_IN_LEN, ST_IN_CHK, ST_IN_CMP, ST_IN_FIX, ST_IN_FIX2,
        ST_DONE
    } fsm_t;

    function automatic byte_t idx_byte(input idx_t h);
        idx_byte = {1'b0, h, 2'b00};
    endfunction

    function automatic byte_t pay_addr(input idx_t h);
        pay_addr = idx_byte(h) + BYTE_W'(HDR_BYTES);
    endfunction

    // Payload length of the block at h whose physical successor is nxt.
    function automatic byte_t plen(input byte_t nxt, input idx_t h);
        plen = nxt - pay_addr(h);
    endfunction

endpackage
`default_nettype wire

@@ src/best_fit_heap_allocator.sv @@
// Top level of the best-fit heap allocator: sequencer, header memories, ports.
`timescale 1ns / 1ps
`default_nettype none
// Each step of a free-list walk is one registered header memory read.
// Throughput: one request at a time; s_ready is high only in the idle state.
// Reset and every heap_limit write start a clearing pass over the block-start
// bits, during which no request is taken.
module best_fit_heap_allocator
    import bfha_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data,
    input  wire logic      cfg_wr_en,
    input  wire logic [1:0] cfg_wr_idx,
    input  wire byte_t     cfg_wr_data
);

    // Header memories, one entry per 4-byte header position.
    logic  mem_live [DEPTH];
    logic  mem_free [DEPTH];
    link_t mem_link [DEPTH];
    link_t mem_prev [DEPTH];
    byte_t mem_next [DEPTH];

    logic  q_live, q_free;
    link_t q_link, q_prev;
    byte_t q_next;

    idx_t  rd_idx;
    logic  live_we, free_we, link_we, prev_we, next_we;
    idx_t  live_wa, free_wa, link_wa, prev_wa, next_wa;
    logic  live_wd, free_wd;
    link_t link_wd, prev_wd;
    byte_t next_wd;

    fsm_t  state_reg, state_next, ret_reg, ret_next;
    logic [1:0] op_reg, op_next;
    byte_t addr_reg, addr_next, size_reg, size_next;
    logic [SIZE_W-1:0] s_reg, s_next;
    link_t cur_reg, cur_next, prv_reg, prv_next, g_reg, g_next, head_reg, head_next;
    idx_t  tgt_reg, tgt_next, h_reg, h_next, cvh_reg, cvh_next, m_reg, m_next;
    idx_t  p_reg, p_next;
    byte_t len_reg, len_next, glen_reg, glen_next, old_reg, old_next;
    byte_t n_reg, n_next, nn_reg, nn_next, len2_reg, len2_next;
    byte_t hlen_reg, hlen_next, nb_reg, nb_next;
    logic  cvg_reg, cvg_next;
    logic [1:0] st_reg, st_next;
    byte_t res_reg, res_next, gsz_reg, gsz_next, cpb_reg, cpb_next;
    logic  cp_reg, cp_next;
    byte_t limit_reg, limit_next;
    logic [3:0] glog_reg, glog_next;
    idx_t  clr_reg, clr_next;
    logic  mvalid_reg, mvalid_next;
    out_item_t mdata_reg, mdata_next;

    // Request decode helpers.
    byte_t a12;
    logic  addr_bad;
    logic [SIZE_W:0] s_plus;
    logic [SIZE_W-1:0] gmask, rsize;
    byte_t lim_sat;
    logic [3:0] glog_sat;
    logic  resize_move;

    assign a12      = addr_reg - BYTE_W'(HDR_BYTES);
    assign addr_bad = (addr_reg < BYTE_W'(HDR_BYTES)) || (a12 >= limit_reg) ||
                      (a12[1:0] != 2'b00);
    assign s_plus   = {1'b0, s_reg} + (SIZE_W+1)'(HDR_BYTES);
    assign gmask    = (SIZE_W'(1) << glog_reg) - SIZE_W'(1);
    assign rsize    = ({1'b0, s_data.req_size} + gmask) & ~gmask;
    assign resize_move = (op_reg == OP_RESIZE) && (size_reg != '0);

    always_comb begin
        if (cfg_wr_data < BYTE_W'(LIMIT_MIN)) begin
            lim_sat = BYTE_W'(LIMIT_MIN);
        end else if (cfg_wr_data > BYTE_W'(HEAP_BYTES)) begin
            lim_sat = BYTE_W'(HEAP_BYTES);
        end else begin
            lim_sat = cfg_wr_data;
        end
        if (cfg_wr_data[3:0] < 4'(GLOG_MIN)) begin
            glog_sat = 4'(GLOG_MIN);
        end else if (cfg_wr_data[3:0] > 4'(GLOG_MAX)) begin
            glog_sat = 4'(GLOG_MAX);
        end else begin
            glog_sat = cfg_wr_data[3:0];
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mvalid_reg;
    assign m_data  = mdata_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR: begin
                if (clr_reg == idx_t'(DEPTH - 1)) state_next = ST_INIT;
            end
            ST_INIT: state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_valid) state_next = ST_DISP;
            end
            ST_DISP: begin
                case (op_reg)
                    OP_ALLOC: state_next = ST_GR_CHK;
                    OP_RESERVE: begin
                        if (head_reg[IDX_W]) state_next = ST_DONE;
                        else if (size_reg != '0) state_next = ST_GR_CHK;
                        else state_next = ST_LG_RD;
                    end
                    default: state_next = addr_bad ? ST_DONE : ST_CHK;
                endcase
            end
            ST_CHK: begin
                if (!q_live || q_free) state_next = ST_DONE;
                else if (op_reg == OP_FREE || size_reg == '0) state_next = ST_RL0;
                else state_next = ST_RZ0;
            end
            ST_RZ0: begin
                if ({1'b0, hlen_reg} >= s_reg) begin
                    state_next = ({2'b0, hlen_reg} > s_plus) ? ST_CV0 : ST_DONE;
                end else if (nb_reg == limit_reg) begin
                    state_next = ST_GR_CHK;
                end else begin
                    state_next = ST_RZ1;
                end
            end
            ST_RZ1: begin
                if (q_free && ({1'b0, q_next - addr_reg} >= s_reg)) state_next = ST_RM_CHK;
                else state_next = ST_GR_CHK;
            end
            ST_RZ2: state_next = ({2'b0, len2_reg} > s_plus) ? ST_CV0 : ST_DONE;
            ST_GR_CHK: state_next = cur_reg[IDX_W] ? ST_GR_END : ST_GR_CMP;
            ST_GR_CMP: begin
                if ({1'b0, plen(q_next, cur_reg[IDX_W-1:0])} >= s_reg) state_next = ST_RM_CHK;
                else state_next = ST_GR_CHK;
            end
            ST_GR_CV: state_next = ({2'b0, glen_reg} > s_plus) ? ST_CV0 : ST_GR_END;
            ST_GR_END: begin
                if (op_reg == OP_RESIZE) state_next = ST_RL0;
                else if (op_reg == OP_RESERVE && !g_reg[IDX_W]) state_next = ST_GR_SZ;
                else state_next = ST_DONE;
            end
            ST_GR_SZ:  state_next = ST_GR_SZ2;
            ST_GR_SZ2: state_next = ST_DONE;
            ST_LG_RD:  state_next = ST_LG_CMP;
            ST_LG_CMP: state_next = q_link[IDX_W] ? ST_RM_CHK : ST_LG_RD;
            ST_LG_SZ:  state_next = ST_LG_SZ2;
            ST_LG_SZ2: state_next = ST_DONE;
            ST_CV0: state_next = ST_CV1;
            ST_CV1: state_next = ST_CV2;
            ST_CV2: state_next = ST_CV3;
            ST_CV3: begin
                if (old_reg == limit_reg) state_next = ST_CV_INS;
                else if (q_free) state_next = ST_RM_CHK;
                else state_next = ST_CV_INS;
            end
            ST_CV4: state_next = ST_CV5;
            ST_CV5: state_next = ST_CV_INS;
            ST_CV_INS: state_next = ST_IN_RD;
            ST_CV_END: state_next = cvg_reg ? ST_GR_END : ST_DONE;
            ST_RL0: state_next = ST_RL1;
            ST_RL1: state_next = ST_RL2;
            ST_RL2: state_next = ST_RL3;
            ST_RL3: state_next = (n_reg != limit_reg && q_free) ? ST_RM_CHK : ST_RL6;
            ST_RL4: state_next = ST_RL5;
            ST_RL5: state_next = ST_RL6;
            ST_RL6: state_next = ST_RL7;
            ST_RL7: state_next = q_prev[IDX_W] ? ST_IN_RD : ST_RL8;
            ST_RL8: state_next = ST_RL9;
            ST_RL9: state_next = q_free ? ST_RM_CHK : ST_IN_RD;
            ST_RL10: state_next = ST_RL11;
            ST_RL11: state_next = ST_IN_RD;
            ST_RL_END: state_next = ST_DONE;
            ST_RM_CHK: begin
                if (cur_reg[IDX_W]) state_next = ret_reg;
                else if (cur_reg[IDX_W-1:0] == tgt_reg) state_next = ST_RM_FIX;
                else state_next = ST_RM_ADV;
            end
            ST_RM_ADV:  state_next = ST_RM_CHK;
            ST_RM_FIX:  state_next = ST_RM_FIX2;
            ST_RM_FIX2: state_next = ret_reg;
            ST_IN_RD:   state_next = ST_IN_LEN;
            ST_IN_LEN:  state_next = ST_IN_CHK;
            ST_IN_CHK:  state_next = cur_reg[IDX_W] ? ST_IN_FIX : ST_IN_CMP;
            ST_IN_CMP: begin
                if (len_reg <= plen(q_next, cur_reg[IDX_W-1:0])) state_next = ST_IN_FIX;
                else state_next = ST_IN_CHK;
            end
            ST_IN_FIX:  state_next = ST_IN_FIX2;
            ST_IN_FIX2: state_next = ret_reg;
            ST_DONE: begin
                if (!mvalid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        // A heap_limit write rebuilds the heap from scratch.
        if (cfg_wr_en && cfg_wr_idx == CFG_HEAP_LIMIT) state_next = ST_CLR;
    end

    // Datapath, memory ports and register updates.
    always_comb begin
        ret_next = ret_reg;   op_next = op_reg;     addr_next = addr_reg;
        size_next = size_reg; s_next = s_reg;       cur_next = cur_reg;
        prv_next = prv_reg;   g_next = g_reg;       head_next = head_reg;
        tgt_next = tgt_reg;   h_next = h_reg;       cvh_next = cvh_reg;
        m_next = m_reg;       p_next = p_reg;       len_next = len_reg;
        glen_next = glen_reg; old_next = old_reg;   n_next = n_reg;
        nn_next = nn_reg;     len2_next = len2_reg; hlen_next = hlen_reg;
        nb_next = nb_reg;     cvg_next = cvg_reg;   st_next = st_reg;
        res_next = res_reg;   gsz_next = gsz_reg;   cp_next = cp_reg;
        cpb_next = cpb_reg;   limit_next = limit_reg; glog_next = glog_reg;
        clr_next = clr_reg;   mvalid_next = mvalid_reg; mdata_next = mdata_reg;

        rd_idx = cur_reg[IDX_W-1:0];
        live_we = 1'b0; live_wa = '0; live_wd = 1'b0;
        free_we = 1'b0; free_wa = '0; free_wd = 1'b0;
        link_we = 1'b0; link_wa = '0; link_wd = LINK_NIL;
        prev_we = 1'b0; prev_wa = '0; prev_wd = LINK_NIL;
        next_we = 1'b0; next_wa = '0; next_wd = '0;

        // Drop the result once the consumer takes it.
        if (mvalid_reg && m_ready) mvalid_next = 1'b0;

        case (state_reg)
            ST_CLR: begin
                live_we = 1'b1; live_wa = clr_reg; live_wd = 1'b0;
                clr_next = clr_reg + idx_t'(1);
            end
            ST_INIT: begin
                live_we = 1'b1; live_wa = '0; live_wd = 1'b1;
                free_we = 1'b1; free_wa = '0; free_wd = 1'b1;
                link_we = 1'b1; link_wa = '0; link_wd = LINK_NIL;
                prev_we = 1'b1; prev_wa = '0; prev_wd = LINK_NIL;
                next_we = 1'b1; next_wa = '0; next_wd = limit_reg;
                head_next = '0;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next   = s_data.operation;
                    addr_next = s_data.block_addr;
                    size_next = s_data.req_size;
                    s_next    = rsize;
                    st_next = STS_OK; res_next = '0; gsz_next = '0;
                    cp_next = 1'b0;   cpb_next = '0;
                end
            end
            ST_DISP: begin
                rd_idx   = a12[IDX_W+1:2];
                h_next   = a12[IDX_W+1:2];
                cur_next = head_reg;
                case (op_reg)
                    OP_ALLOC: ;
                    OP_RESERVE: begin
                        if (head_reg[IDX_W]) st_next = STS_NO_SPACE;
                    end
                    default: begin
                        if (addr_bad) st_next = STS_BAD_ADDR;
                    end
                endcase
            end
            ST_CHK: begin
                if (!q_live) begin
                    st_next = STS_BAD_ADDR;
                end else if (q_free) begin
                    st_next = STS_IS_FREE;
                end
                hlen_next = plen(q_next, h_reg);
                nb_next   = q_next;
            end
            ST_RZ0: begin
                rd_idx = nb_reg[IDX_W+1:2];
                cvh_next = h_reg;
                cvg_next = 1'b0;
                if ({1'b0, hlen_reg} >= s_reg) begin
                    if ({2'b0, hlen_reg} <= s_plus) res_next = addr_reg;
                end
            end
            ST_RZ1: begin
                // Grow in place into the free neighbor: unlink it first.
                len2_next = q_next - addr_reg;
                nn_next   = q_next;
                tgt_next  = nb_reg[IDX_W+1:2];
                ret_next  = ST_RZ2;
                prv_next  = LINK_NIL;
            end
            ST_RZ2: begin
                next_we = 1'b1; next_wa = h_reg; next_wd = nn_reg;
                live_we = 1'b1; live_wa = nb_reg[IDX_W+1:2]; live_wd = 1'b0;
                if (nn_reg != limit_reg) begin
                    prev_we = 1'b1; prev_wa = nn_reg[IDX_W+1:2]; prev_wd = {1'b0, h_reg};
                end
                if ({2'b0, len2_reg} <= s_plus) res_next = addr_reg;
            end
            ST_GR_CHK: begin
                if (cur_reg[IDX_W]) g_next = LINK_NIL;
            end
            ST_GR_CMP: begin
                if ({1'b0, plen(q_next, cur_reg[IDX_W-1:0])} >= s_reg) begin
                    g_next    = cur_reg;
                    glen_next = plen(q_next, cur_reg[IDX_W-1:0]);
                    tgt_next  = cur_reg[IDX_W-1:0];
                    ret_next  = ST_GR_CV;
                    prv_next  = LINK_NIL;
                    cur_next  = head_reg;
                end else begin
                    cur_next = q_link;
                end
            end
            ST_GR_CV: begin
                cvh_next = g_reg[IDX_W-1:0];
                cvg_next = 1'b1;
            end
            ST_GR_END: begin
                if (g_reg[IDX_W]) begin
                    if (op_reg != OP_RESIZE) st_next = STS_NO_SPACE;
                end else if (op_reg != OP_RESIZE) begin
                    res_next = pay_addr(g_reg[IDX_W-1:0]);
                end
            end
            ST_GR_SZ:  rd_idx = g_reg[IDX_W-1:0];
            ST_GR_SZ2: gsz_next = plen(q_next, g_reg[IDX_W-1:0]);
            ST_LG_CMP: begin
                // Advance to the tail of the list, which holds the largest block.
                if (q_link[IDX_W]) begin
                    tgt_next = cur_reg[IDX_W-1:0];
                    ret_next = ST_LG_SZ;
                    prv_next = LINK_NIL;
                    cur_next = head_reg;
                end else begin
                    cur_next = q_link;
                end
            end
            ST_LG_SZ:  rd_idx = tgt_reg;
            ST_LG_SZ2: begin
                gsz_next = plen(q_next, tgt_reg);
                res_next = pay_addr(tgt_reg);
            end
            ST_CV0: rd_idx = cvh_reg;
            ST_CV1: begin
                old_next = q_next;
                m_next   = idx_t'({3'b0, cvh_reg} + BYTE_W'(HDR_WORDS) +
                                  BYTE_W'(s_reg[SIZE_W-1:2]));
                next_we = 1'b1; next_wa = cvh_reg;
                next_wd = idx_byte(idx_t'({3'b0, cvh_reg} + BYTE_W'(HDR_WORDS) +
                                          BYTE_W'(s_reg[SIZE_W-1:2])));
            end
            ST_CV2: begin
                rd_idx = old_reg[IDX_W+1:2];
                prev_we = 1'b1; prev_wa = m_reg; prev_wd = {1'b0, cvh_reg};
                next_we = 1'b1; next_wa = m_reg; next_wd = old_reg;
                free_we = 1'b1; free_wa = m_reg; free_wd = 1'b0;
                live_we = 1'b1; live_wa = m_reg; live_wd = 1'b1;
            end
            ST_CV3: begin
                if (old_reg != limit_reg) begin
                    if (q_free) begin
                        tgt_next = old_reg[IDX_W+1:2];
                        ret_next = ST_CV4;
                        prv_next = LINK_NIL;
                        cur_next = head_reg;
                    end else begin
                        prev_we = 1'b1; prev_wa = old_reg[IDX_W+1:2];
                        prev_wd = {1'b0, m_reg};
                    end
                end
            end
            ST_CV4: rd_idx = old_reg[IDX_W+1:2];
            ST_CV5: begin
                next_we = 1'b1; next_wa = m_reg; next_wd = q_next;
                live_we = 1'b1; live_wa = old_reg[IDX_W+1:2]; live_wd = 1'b0;
                if (q_next != limit_reg) begin
                    prev_we = 1'b1; prev_wa = q_next[IDX_W+1:2]; prev_wd = {1'b0, m_reg};
                end
            end
            ST_CV_INS: begin
                tgt_next = m_reg;
                ret_next = ST_CV_END;
            end
            ST_CV_END: begin
                if (!cvg_reg) res_next = addr_reg;
            end
            ST_RL0: rd_idx = h_reg;
            ST_RL1: n_next = q_next;
            ST_RL2: rd_idx = n_reg[IDX_W+1:2];
            ST_RL3: begin
                if (n_reg != limit_reg && q_free) begin
                    tgt_next = n_reg[IDX_W+1:2];
                    ret_next = ST_RL4;
                    prv_next = LINK_NIL;
                    cur_next = head_reg;
                end
            end
            ST_RL4: rd_idx = n_reg[IDX_W+1:2];
            ST_RL5: begin
                next_we = 1'b1; next_wa = h_reg; next_wd = q_next;
                live_we = 1'b1; live_wa = n_reg[IDX_W+1:2]; live_wd = 1'b0;
                if (q_next != limit_reg) begin
                    prev_we = 1'b1; prev_wa = q_next[IDX_W+1:2]; prev_wd = {1'b0, h_reg};
                end
            end
            ST_RL6: rd_idx = h_reg;
            ST_RL7: begin
                p_next = q_prev[IDX_W-1:0];
                if (q_prev[IDX_W]) begin
                    tgt_next = h_reg;
                    ret_next = ST_RL_END;
                end
            end
            ST_RL8: rd_idx = p_reg;
            ST_RL9: begin
                if (q_free) begin
                    tgt_next = p_reg;
                    ret_next = ST_RL10;
                    prv_next = LINK_NIL;
                    cur_next = head_reg;
                end else begin
                    tgt_next = h_reg;
                    ret_next = ST_RL_END;
                end
            end
            ST_RL10: rd_idx = h_reg;
            ST_RL11: begin
                // Fold this block into its free predecessor.
                next_we = 1'b1; next_wa = p_reg; next_wd = q_next;
                live_we = 1'b1; live_wa = h_reg; live_wd = 1'b0;
                if (q_next != limit_reg) begin
                    prev_we = 1'b1; prev_wa = q_next[IDX_W+1:2]; prev_wd = {1'b0, p_reg};
                end
                tgt_next = p_reg;
                ret_next = ST_RL_END;
            end
            ST_RL_END: begin
                if (resize_move) begin
                    if (g_reg[IDX_W]) begin
                        st_next = STS_NO_SPACE;
                    end else begin
                        res_next = pay_addr(g_reg[IDX_W-1:0]);
                        cp_next  = 1'b1;
                        cpb_next = hlen_reg;
                    end
                end
            end
            ST_RM_CHK: rd_idx = cur_reg[IDX_W-1:0];
            ST_RM_ADV: begin
                prv_next = cur_reg;
                cur_next = q_link;
            end
            ST_RM_FIX: begin
                if (prv_reg[IDX_W]) begin
                    head_next = q_link;
                end else begin
                    link_we = 1'b1; link_wa = prv_reg[IDX_W-1:0]; link_wd = q_link;
                end
            end
            ST_RM_FIX2: begin
                link_we = 1'b1; link_wa = tgt_reg; link_wd = LINK_NIL;
                free_we = 1'b1; free_wa = tgt_reg; free_wd = 1'b0;
            end
            ST_IN_RD: rd_idx = tgt_reg;
            ST_IN_LEN: begin
                len_next = plen(q_next, tgt_reg);
                prv_next = LINK_NIL;
                cur_next = head_reg;
            end
            ST_IN_CHK: rd_idx = cur_reg[IDX_W-1:0];
            ST_IN_CMP: begin
                if (len_reg > plen(q_next, cur_reg[IDX_W-1:0])) begin
                    prv_next = cur_reg;
                    cur_next = q_link;
                end
            end
            ST_IN_FIX: begin
                link_we = 1'b1; link_wa = tgt_reg; link_wd = cur_reg;
                free_we = 1'b1; free_wa = tgt_reg; free_wd = 1'b1;
            end
            ST_IN_FIX2: begin
                if (prv_reg[IDX_W]) begin
                    head_next = {1'b0, tgt_reg};
                end else begin
                    link_we = 1'b1; link_wa = prv_reg[IDX_W-1:0]; link_wd = {1'b0, tgt_reg};
                end
            end
            ST_DONE: begin
                if (!mvalid_reg || m_ready) begin
                    mvalid_next = 1'b1;
                    mdata_next.status       = st_reg;
                    mdata_next.result_addr  = res_reg;
                    mdata_next.granted_size = gsz_reg;
                    mdata_next.copy_needed  = cp_reg;
                    mdata_next.copy_bytes   = cpb_reg;
                end
            end
            default: ;
        endcase

        // Remove calls are entered with a fresh walk from the list head.
        if ((state_reg == ST_RZ1) || (state_reg == ST_LG_CMP && q_link[IDX_W])) begin
            cur_next = head_reg;
        end

        if (cfg_wr_en) begin
            if (cfg_wr_idx == CFG_HEAP_LIMIT) begin
                limit_next = lim_sat;
                clr_next   = '0;
            end else if (cfg_wr_idx == CFG_GRANULE) begin
                glog_next = glog_sat;
            end
        end
    end

    // Header memories: one write and one registered read per array per cycle.
    always_ff @(posedge aclk) begin
        if (live_we) mem_live[live_wa] <= live_wd;
        q_live <= mem_live[rd_idx];
    end
    always_ff @(posedge aclk) begin
        if (free_we) mem_free[free_wa] <= free_wd;
        q_free <= mem_free[rd_idx];
    end
    always_ff @(posedge aclk) begin
        if (link_we) mem_link[link_wa] <= link_wd;
        q_link <= mem_link[rd_idx];
    end
    always_ff @(posedge aclk) begin
        if (prev_we) mem_prev[prev_wa] <= prev_wd;
        q_prev <= mem_prev[rd_idx];
    end
    always_ff @(posedge aclk) begin
        if (next_we) mem_next[next_wa] <= next_wd;
        q_next <= mem_next[rd_idx];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLR;
            clr_reg    <= '0;
            limit_reg  <= BYTE_W'(HEAP_BYTES);
            glog_reg   <= 4'(GLOG_MIN);
            mvalid_reg <= 1'b0;
            head_reg   <= '0;
            ret_reg    <= ST_IDLE;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            limit_reg  <= limit_next;
            glog_reg   <= glog_next;
            mvalid_reg <= mvalid_next;
            head_reg   <= head_next;
            ret_reg    <= ret_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge aclk) begin
        op_reg <= op_next;     addr_reg <= addr_next; size_reg <= size_next;
        s_reg <= s_next;       cur_reg <= cur_next;   prv_reg <= prv_next;
        g_reg <= g_next;       tgt_reg <= tgt_next;   h_reg <= h_next;
        cvh_reg <= cvh_next;   m_reg <= m_next;       p_reg <= p_next;
        len_reg <= len_next;   glen_reg <= glen_next; old_reg <= old_next;
        n_reg <= n_next;       nn_reg <= nn_next;     len2_reg <= len2_next;
        hlen_reg <= hlen_next; nb_reg <= nb_next;     cvg_reg <= cvg_next;
        st_reg <= st_next;     res_reg <= res_next;   gsz_reg <= gsz_next;
        cp_reg <= cp_next;     cpb_reg <= cpb_next;   mdata_reg <= mdata_next;
    end

`ifndef SYNTHESIS
    a_limit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (limit_reg >= BYTE_W'(LIMIT_MIN)) && (limit_reg <= BYTE_W'(HEAP_BYTES)))
        else $error("heap limit out of range");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");
    a_rebuild_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && cfg_wr_idx == CFG_HEAP_LIMIT |=> !s_ready)
        else $error("request taken during heap rebuild");
    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STS_OK |-> m_data.result_addr == '0 &&
        !m_data.copy_needed)
        else $error("failed request carries a grant");
`endif

endmodule
`default_nettype wire
